// ===== rtl/pcsd_pkg.sv =====
// pcsd_pkg: types, character codes and the name table shared by the
// pattern code strip decoder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pcsd_pkg;

   localparam int DEF_MAX_STRIPS = 16;
   localparam int DEF_MAX_COLS   = 256;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_M     = 8'h6D;
   localparam logic [7:0] CH_P     = 8'h70;
   localparam logic [7:0] CH_Q     = 8'h71;
   localparam logic [7:0] CH_S     = 8'h73;
   localparam logic [7:0] CH_W     = 8'h77;
   localparam logic [7:0] CH_X     = 8'h78;
   localparam logic [7:0] CH_Y     = 8'h79;
   localparam logic [7:0] CH_Z     = 8'h7A;

   localparam logic [3:0] METH_LAST = 4'd9;

   localparam logic [1:0] PK_STILL  = 2'd0;
   localparam logic [1:0] PK_OSC    = 2'd1;
   localparam logic [1:0] PK_SHIP   = 2'd2;
   localparam logic [1:0] PK_METH   = 2'd3;

   localparam logic [1:0] RK_HEADER = 2'd0;
   localparam logic [1:0] RK_COLUMN = 2'd1;
   localparam logic [1:0] RK_SIZE   = 2'd2;
   localparam logic [1:0] RK_ERROR  = 2'd3;

   typedef enum logic [2:0] {
      HS_START,
      HS_X,
      HS_METH,
      HS_DIGITS,
      HS_BODY
   } hdr_state_type;

   typedef enum logic [1:0] {
      STEP_NONE,
      STEP_HEADER,
      STEP_COLUMN,
      STEP_ERROR
   } step_type;

   // classified character as it travels from front to back
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       b36_ok;
      logic [5:0] b36_val;
   } tok_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  pattern_kind;
      logic [15:0] header_number;
      logic [3:0]  strip;
      logic [7:0]  column;
      logic [4:0]  cells;
      logic [6:0]  grid_height;
      logic [8:0]  grid_width;
   } rsp_type;

   function automatic logic [7:0] meth_char(input logic [3:0] idx);
      logic [7:0] c;
      unique case (idx)
         4'd0:    c = 8'h6D; // m
         4'd1:    c = 8'h65; // e
         4'd2:    c = 8'h74; // t
         4'd3:    c = 8'h68; // h
         4'd4:    c = 8'h75; // u
         4'd5:    c = 8'h73; // s
         4'd6:    c = 8'h65; // e
         4'd7:    c = 8'h6C; // l
         4'd8:    c = 8'h61; // a
         4'd9:    c = 8'h68; // h
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/pcsd_if.sv =====
// pcsd_req_if / pcsd_rsp_if: valid/ready channels of the pattern code
// strip decoder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface pcsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       last;
   modport source (output valid, ch, last, input ready);
   modport sink (input valid, ch, last, output ready);
   modport monitor (input valid, ready, ch, last);
endinterface

interface pcsd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [1:0]  pattern_kind;
   logic [15:0] header_number;
   logic [3:0]  strip;
   logic [7:0]  column;
   logic [4:0]  cells;
   logic [6:0]  grid_height;
   logic [8:0]  grid_width;
   modport source (output valid, kind, pattern_kind, header_number, strip, column, cells,
                   grid_height, grid_width, input ready);
   modport sink (input valid, kind, pattern_kind, header_number, strip, column, cells,
                 grid_height, grid_width, output ready);
   modport monitor (input valid, ready, kind, pattern_kind, header_number, strip, column,
                    cells, grid_height, grid_width);
endinterface
`default_nettype wire

// ===== rtl/pcsd_front.sv =====
// pcsd_front: takes characters from the request channel and classifies them
// into tokens for the queue. Depends on pcsd_pkg and pcsd_if.
`timescale 1ns / 1ps
`default_nettype none
module pcsd_front
   import pcsd_pkg::*;
(
   pcsd_req_if.sink req_chan,
   input  wire logic    q_ready,
   output logic         q_push,
   output tok_type      q_tok
);

   always_comb begin
      q_tok.ch      = req_chan.ch;
      q_tok.last    = req_chan.last;
      q_tok.b36_ok  = 1'b0;
      q_tok.b36_val = 6'd0;
      if (req_chan.ch >= 8'h30 && req_chan.ch <= 8'h39) begin
         q_tok.b36_ok  = 1'b1;
         q_tok.b36_val = 6'(req_chan.ch - 8'h30);
      end else if (req_chan.ch >= 8'h61 && req_chan.ch <= 8'h7A) begin
         q_tok.b36_ok  = 1'b1;
         q_tok.b36_val = 6'(req_chan.ch - 8'h61 + 8'd10);
      end
   end

   assign req_chan.ready = q_ready;
   assign q_push         = req_chan.valid & q_ready;

endmodule
`default_nettype wire

// ===== rtl/pcsd_queue.sv =====
// pcsd_queue: short token queue between the front and back parts.
// Depends on pcsd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pcsd_queue
   import pcsd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  tok_type      push_tok,
   output logic         push_ready,
   input  wire logic    pop,
   output logic         pop_valid,
   output tok_type      pop_tok
);

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int NW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
   localparam logic [NW-1:0] FULL_N   = NW'(QUEUE_DEPTH);

   tok_type         mem_ff [QUEUE_DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]   count_ff, count_in;

   assign push_ready = (count_ff != FULL_N);
   assign pop_valid  = (count_ff != '0);
   assign pop_tok    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_IDX) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_IDX) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_tok;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/pcsd_back.sv =====
// pcsd_back: header parser, strip/column tracker and result register.
// Depends on pcsd_pkg and pcsd_if.
`timescale 1ns / 1ps
`default_nettype none
module pcsd_back
   import pcsd_pkg::*;
#(
   parameter int MAX_STRIPS = DEF_MAX_STRIPS,
   parameter int MAX_COLS   = DEF_MAX_COLS
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_valid,
   input  tok_type      q_tok,
   output logic         q_pop,
   pcsd_rsp_if.source   rsp_chan
);

   localparam int SW = $clog2(MAX_STRIPS + 1);
   localparam int CW = $clog2(MAX_COLS + 1);
   localparam logic [SW:0]   MAX_STRIPS_C = (SW + 1)'(MAX_STRIPS);
   localparam logic [CW-1:0] MAX_COLS_C   = CW'(MAX_COLS);
   localparam logic [CW+5:0] MAX_COLS_S   = (CW + 6)'(MAX_COLS);

   hdr_state_type  state_ff, state_in;
   logic [3:0]     meth_idx_ff, meth_idx_in;
   logic [1:0]     kind_reg_ff, kind_reg_in;
   logic [15:0]    number_ff, number_in;
   logic           digits_done_ff, digits_done_in;
   logic           esc_ff, esc_in;
   logic [SW-1:0]  strip_ff, strip_in;
   logic [CW-1:0]  col_ff, col_in;
   logic [CW-1:0]  maxw_ff, maxw_in;
   logic           error_ff, error_in;

   rsp_type        rsp_ff, rsp_in;
   logic           rsp_valid_ff, rsp_valid_in;

   logic           can_take;
   logic [19:0]    num_x10;

   assign can_take = !rsp_valid_ff || rsp_chan.ready;
   assign q_pop    = q_valid && can_take;
   assign num_x10  = ({4'd0, number_ff} << 3) + ({4'd0, number_ff} << 1)
                   + {16'd0, q_tok.b36_val[3:0]};

   always_comb begin
      step_type      r;
      logic          is_digit;
      logic          do_skip;
      logic [5:0]    skip_n;
      logic [CW+5:0] skip_sum;
      logic [SW:0]   strip_inc;
      logic [CW-1:0] col_out;
      logic [SW+3:0] sp1;
      logic          have_res;
      rsp_type       res;

      state_in       = state_ff;
      meth_idx_in    = meth_idx_ff;
      kind_reg_in    = kind_reg_ff;
      number_in      = number_ff;
      digits_done_in = digits_done_ff;
      esc_in         = esc_ff;
      strip_in       = strip_ff;
      col_in         = col_ff;
      maxw_in        = maxw_ff;
      error_in       = error_ff;
      r              = STEP_NONE;
      is_digit       = q_tok.b36_ok && (q_tok.b36_val < 6'd10);
      do_skip        = 1'b0;
      skip_n         = 6'd0;
      skip_sum       = '0;
      strip_inc      = {1'b0, strip_ff} + 1'b1;
      col_out        = col_ff;
      have_res       = 1'b0;
      res            = '0;

      unique case (state_ff)
         HS_START: begin
            if (q_tok.ch == CH_X) begin
               state_in = HS_X;
            end else if (q_tok.ch == CH_M) begin
               state_in    = HS_METH;
               meth_idx_in = 4'd1;
            end else begin
               r = STEP_ERROR;
            end
         end
         HS_X: begin
            state_in = HS_DIGITS;
            if (q_tok.ch == CH_S) begin
               kind_reg_in = PK_STILL;
            end else if (q_tok.ch == CH_P) begin
               kind_reg_in = PK_OSC;
            end else if (q_tok.ch == CH_Q) begin
               kind_reg_in = PK_SHIP;
            end else begin
               r = STEP_ERROR;
            end
         end
         HS_METH: begin
            if (q_tok.ch != meth_char(meth_idx_ff)) begin
               r = STEP_ERROR;
            end else if (meth_idx_ff == METH_LAST) begin
               kind_reg_in = PK_METH;
               state_in    = HS_DIGITS;
            end else begin
               meth_idx_in = meth_idx_ff + 1'b1;
            end
         end
         HS_DIGITS: begin
            if (is_digit) begin
               number_in      = (num_x10 > 20'd65535) ? 16'hFFFF : num_x10[15:0];
               digits_done_in = 1'b1;
            end else if (q_tok.ch == CH_UNDER && digits_done_ff) begin
               state_in = HS_BODY;
               r        = STEP_HEADER;
            end else begin
               r = STEP_ERROR;
            end
         end
         HS_BODY: begin
            if (esc_ff) begin
               esc_in = 1'b0;
               if (!q_tok.b36_ok) begin
                  r = STEP_ERROR;
               end else begin
                  do_skip = 1'b1;
                  skip_n  = q_tok.b36_val + 6'd4;
               end
            end else if (q_tok.b36_ok && q_tok.b36_val < 6'd32) begin
               if (col_ff >= MAX_COLS_C) begin
                  r = STEP_ERROR;
               end else begin
                  r      = STEP_COLUMN;
                  col_in = col_ff + 1'b1;
                  if (col_in > maxw_ff) begin
                     maxw_in = col_in;
                  end
               end
            end else if (q_tok.ch == CH_W) begin
               do_skip = 1'b1;
               skip_n  = 6'd2;
            end else if (q_tok.ch == CH_X) begin
               do_skip = 1'b1;
               skip_n  = 6'd3;
            end else if (q_tok.ch == CH_Y) begin
               esc_in = 1'b1;
            end else if (q_tok.ch == CH_Z) begin
               if (strip_inc >= MAX_STRIPS_C) begin
                  r = STEP_ERROR;
               end else begin
                  strip_in = SW'(strip_inc);
                  col_in   = '0;
               end
            end else begin
               r = STEP_ERROR;
            end
         end
         default: r = STEP_ERROR;
      endcase

      if (do_skip) begin
         skip_sum = {6'd0, col_ff} + {{CW{1'b0}}, skip_n};
         if (skip_sum > MAX_COLS_S) begin
            r = STEP_ERROR;
         end else begin
            col_in = CW'(skip_sum);
            if (col_in > maxw_ff) begin
               maxw_in = col_in;
            end
         end
      end

      sp1 = (SW + 4)'(strip_in) + 1'b1;

      priority if (error_ff) begin
         have_res = q_tok.last;
         res.kind = RK_ERROR;
         error_in = !q_tok.last;
      end else if (r == STEP_ERROR) begin
         have_res = 1'b1;
         res.kind = RK_ERROR;
         error_in = !q_tok.last;
      end else if (q_tok.last) begin
         have_res = 1'b1;
         if (state_in != HS_BODY || esc_in) begin
            res.kind = RK_ERROR;
         end else begin
            res.kind          = RK_SIZE;
            res.pattern_kind  = kind_reg_in;
            res.header_number = number_in;
            res.strip         = 4'(strip_in);
            res.column        = (r == STEP_COLUMN) ? 8'(col_out) : 8'(col_in);
            res.cells         = (r == STEP_COLUMN) ? q_tok.b36_val[4:0] : 5'd0;
            res.grid_height   = 7'((sp1 << 2) + sp1);
            res.grid_width    = 9'(maxw_in);
         end
      end else if (r == STEP_HEADER) begin
         have_res          = 1'b1;
         res.kind          = RK_HEADER;
         res.pattern_kind  = kind_reg_in;
         res.header_number = number_in;
      end else if (r == STEP_COLUMN) begin
         have_res          = 1'b1;
         res.kind          = RK_COLUMN;
         res.pattern_kind  = kind_reg_in;
         res.header_number = number_in;
         res.strip         = 4'(strip_in);
         res.column        = 8'(col_out);
         res.cells         = q_tok.b36_val[4:0];
      end else begin
         have_res = 1'b0;
      end

      // end of code (or of a failed one): back to start
      if (q_tok.last) begin
         state_in       = HS_START;
         meth_idx_in    = 4'd0;
         kind_reg_in    = 2'd0;
         number_in      = 16'd0;
         digits_done_in = 1'b0;
         esc_in         = 1'b0;
         strip_in       = '0;
         col_in         = '0;
         maxw_in        = '0;
         error_in       = 1'b0;
      end

      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (can_take) begin
         rsp_valid_in = q_pop && have_res;
         if (q_pop && have_res) begin
            rsp_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= HS_START;
         meth_idx_ff    <= 4'd0;
         kind_reg_ff    <= 2'd0;
         number_ff      <= 16'd0;
         digits_done_ff <= 1'b0;
         esc_ff         <= 1'b0;
         strip_ff       <= '0;
         col_ff         <= '0;
         maxw_ff        <= '0;
         error_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (q_pop) begin
            state_ff       <= state_in;
            meth_idx_ff    <= meth_idx_in;
            kind_reg_ff    <= kind_reg_in;
            number_ff      <= number_in;
            digits_done_ff <= digits_done_in;
            esc_ff         <= esc_in;
            strip_ff       <= strip_in;
            col_ff         <= col_in;
            maxw_ff        <= maxw_in;
            error_ff       <= error_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.kind          = rsp_ff.kind;
   assign rsp_chan.pattern_kind  = rsp_ff.pattern_kind;
   assign rsp_chan.header_number = rsp_ff.header_number;
   assign rsp_chan.strip         = rsp_ff.strip;
   assign rsp_chan.column        = rsp_ff.column;
   assign rsp_chan.cells         = rsp_ff.cells;
   assign rsp_chan.grid_height   = rsp_ff.grid_height;
   assign rsp_chan.grid_width    = rsp_ff.grid_width;

endmodule
`default_nettype wire

// ===== rtl/pattern_code_strip_decoder.sv =====
// pattern_code_strip_decoder: top level; front classifier, token queue and
// back-end decoder. Depends on pcsd_pkg, pcsd_if, pcsd_front, pcsd_queue, pcsd_back.
//
//  channel   dir  handshake      payload
//  req_chan  in   valid/ready    ch[7:0], last
//  rsp_chan  out  valid/ready    kind, pattern_kind, header_number, strip,
//                                column, cells, grid_height, grid_width
//
// One character per cycle sustained while rsp_chan is not stalled; from accept to result a character
// passes the queue entry, then the result register written by the back-end decode.
// The back-end state update is the loop that sets this rate.
// Synchronous reset clears the queue, the decoder state and the result valid flag.
// A stalled result holds the back end; the two-entry queue then fills and
// req_chan.ready drops. req_chan.ready never depends on rsp_chan.ready in the same cycle.
`timescale 1ns / 1ps
`default_nettype none
module pattern_code_strip_decoder
   import pcsd_pkg::*;
#(
   parameter int MAX_STRIPS = DEF_MAX_STRIPS,
   parameter int MAX_COLS   = DEF_MAX_COLS
) (
   input  wire logic  clock,
   input  wire logic  reset,
   pcsd_req_if.sink   req_chan,
   pcsd_rsp_if.source rsp_chan
);

   logic    q_push, q_ready, q_pop, q_valid;
   tok_type push_tok, pop_tok;

   pcsd_front u_front (
      .req_chan (req_chan),
      .q_ready  (q_ready),
      .q_push   (q_push),
      .q_tok    (push_tok)
   );

   pcsd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_tok   (push_tok),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_tok    (pop_tok)
   );

   pcsd_back #(
      .MAX_STRIPS (MAX_STRIPS),
      .MAX_COLS   (MAX_COLS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_tok    (pop_tok),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule
`default_nettype wire

// ===== rtl/pcsd_checker.sv =====
// pcsd_checker: port-level assertions for the pattern code strip decoder,
// bound to the top level. Depends on pcsd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pcsd_checker
   import pcsd_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_kind,
   input wire logic [1:0]  rsp_pattern_kind,
   input wire logic [15:0] rsp_header_number,
   input wire logic [3:0]  rsp_strip,
   input wire logic [7:0]  rsp_column,
   input wire logic [4:0]  rsp_cells,
   input wire logic [6:0]  rsp_grid_height,
   input wire logic [8:0]  rsp_grid_width
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_column) && $stable(rsp_cells)
         && $stable(rsp_header_number))
      else $error("result dropped or changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == RK_ERROR |->
         rsp_pattern_kind == 2'd0 && rsp_header_number == 16'd0
         && rsp_strip == 4'd0 && rsp_column == 8'd0 && rsp_cells == 5'd0
         && rsp_grid_height == 7'd0 && rsp_grid_width == 9'd0)
      else $error("error item carries data");

   a_size_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == RK_HEADER || rsp_kind == RK_COLUMN) |->
         rsp_grid_height == 7'd0 && rsp_grid_width == 9'd0)
      else $error("grid size outside the final item");

   a_size_height: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == RK_SIZE |-> rsp_grid_height != 7'd0)
      else $error("final item with zero height");

endmodule

bind pattern_code_strip_decoder pcsd_checker u_pcsd_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_kind          (rsp_chan.kind),
   .rsp_pattern_kind  (rsp_chan.pattern_kind),
   .rsp_header_number (rsp_chan.header_number),
   .rsp_strip         (rsp_chan.strip),
   .rsp_column        (rsp_chan.column),
   .rsp_cells         (rsp_chan.cells),
   .rsp_grid_height   (rsp_chan.grid_height),
   .rsp_grid_width    (rsp_chan.grid_width)
);
`default_nettype wire

// ===== tb/tb.sv =====
// tb: self-checking bench for pattern_code_strip_decoder. Streams a directed
// table and random pattern codes, predicts each result item and checks them in order.
// Depends on pcsd_pkg, pcsd_req_if/pcsd_rsp_if and the decoder RTL.
`timescale 1ns / 1ps
module tb;
   import pcsd_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int CHAR_TARGET = 1340;
   localparam int CALM_TAIL   = 150;

   localparam rsp_type NO_RSP  = '0;
   localparam rsp_type ERR_RSP = '{kind: RK_ERROR, default: '0};

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       typed;
      rsp_type    want;
   } table_row_type;

   typedef struct {
      logic [7:0] ch;
      logic       last;
      bit         typed;
      bit         drain;
      rsp_type    want;
   } code_char_type;

   logic clock = 1'b0;
   logic reset;

   pcsd_req_if req_if ();
   pcsd_rsp_if rsp_if ();

   pattern_code_strip_decoder DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // decoder state as predicted
   hdr_state_type phase;
   int            meth_pos;
   logic [1:0]    pat_kind;
   int            hdr_num;
   bit            digits_seen;
   bit            esc_wait;
   int            strip_cnt;
   int            col_cnt;
   int            width_max;
   bit            err_seen;

   string         meth_word = "methuselah";
   code_char_type code_chars [$];
   rsp_type       rsp_due [$];
   int            acc_idx = 0;
   int            codes_done = 0;
   int            fail_count = 0;
   int            cycles = 0;
   int            rsp_count [4] = '{0, 0, 0, 0};
   int            send_rate = 0;
   int            rcv_rate = 0;

   function automatic rsp_type want_rsp(input logic [1:0] k, pk, input int num, s, col, cl,
                                        h, w);
      rsp_type r;
      r.kind          = k;
      r.pattern_kind  = pk;
      r.header_number = 16'(num);
      r.strip         = 4'(s);
      r.column        = 8'(col);
      r.cells         = 5'(cl);
      r.grid_height   = 7'(h);
      r.grid_width    = 9'(w);
      return r;
   endfunction

   function automatic logic [7:0] digit36(input int v);
      return (v < 10) ? 8'("0" + v) : 8'("a" + v - 10);
   endfunction

   function automatic string show_rsp(input rsp_type r);
      return $sformatf("kind=%0d pk=%0d num=%0d strip=%0d col=%0d cells=%0d h=%0d w=%0d",
                       r.kind, r.pattern_kind, r.header_number, r.strip, r.column,
                       r.cells, r.grid_height, r.grid_width);
   endfunction

   function automatic void clear_decoder();
      phase       = HS_START;
      meth_pos    = 0;
      pat_kind    = PK_STILL;
      hdr_num     = 0;
      digits_seen = 1'b0;
      esc_wait    = 1'b0;
      strip_cnt   = 0;
      col_cnt     = 0;
      width_max   = 0;
      err_seen    = 1'b0;
   endfunction

   function automatic void decode_char(input logic [7:0] c, input logic lst,
                                       output bit made, output rsp_type r);
      step_type st;
      int       v, skip_n, bm_col, bm_cells;
      r        = NO_RSP;
      made     = 1'b0;
      st       = STEP_NONE;
      skip_n   = 0;
      bm_col   = 0;
      bm_cells = 0;
      // after an error only the last character answers
      if (err_seen) begin
         if (lst) begin
            r    = ERR_RSP;
            made = 1'b1;
            clear_decoder();
         end
         return;
      end
      if (c >= "0" && c <= "9") v = c - "0";
      else if (c >= "a" && c <= "z") v = c - "a" + 10;
      else v = -1;
      case (phase)
         HS_START: begin
            if (c == CH_X) begin
               phase = HS_X;
            end else if (c == CH_M) begin
               phase    = HS_METH;
               meth_pos = 1;
            end else begin
               st = STEP_ERROR;
            end
         end
         HS_X: begin
            if (c == CH_S) pat_kind = PK_STILL;
            else if (c == CH_P) pat_kind = PK_OSC;
            else if (c == CH_Q) pat_kind = PK_SHIP;
            else st = STEP_ERROR;
            if (st != STEP_ERROR) phase = HS_DIGITS;
         end
         HS_METH: begin
            if (c != meth_word[meth_pos]) begin
               st = STEP_ERROR;
            end else if (meth_pos == METH_LAST) begin
               pat_kind = PK_METH;
               phase    = HS_DIGITS;
            end else begin
               meth_pos++;
            end
         end
         HS_DIGITS: begin
            if (c >= "0" && c <= "9") begin
               hdr_num = hdr_num * 10 + v;
               if (hdr_num > 65535) hdr_num = 65535;
               digits_seen = 1'b1;
            end else if (c == CH_UNDER && digits_seen) begin
               phase = HS_BODY;
               st    = STEP_HEADER;
            end else begin
               st = STEP_ERROR;
            end
         end
         HS_BODY: begin
            if (esc_wait) begin
               esc_wait = 1'b0;
               if (v < 0) st = STEP_ERROR;
               else skip_n = v + 4;
            end else if (v >= 0 && v < 32) begin
               if (col_cnt >= DEF_MAX_COLS) begin
                  st = STEP_ERROR;
               end else begin
                  bm_col   = col_cnt;
                  bm_cells = v;
                  col_cnt++;
                  if (col_cnt > width_max) width_max = col_cnt;
                  st = STEP_COLUMN;
               end
            end else if (c == CH_W) begin
               skip_n = 2;
            end else if (c == CH_X) begin
               skip_n = 3;
            end else if (c == CH_Y) begin
               esc_wait = 1'b1;
            end else if (c == CH_Z) begin
               if (strip_cnt + 1 >= DEF_MAX_STRIPS) begin
                  st = STEP_ERROR;
               end else begin
                  strip_cnt++;
                  col_cnt = 0;
               end
            end else begin
               st = STEP_ERROR;
            end
            if (skip_n > 0) begin
               if (col_cnt + skip_n > DEF_MAX_COLS) begin
                  st = STEP_ERROR;
               end else begin
                  col_cnt += skip_n;
                  if (col_cnt > width_max) width_max = col_cnt;
               end
            end
         end
         default: st = STEP_ERROR;
      endcase

      if (st == STEP_ERROR) begin
         r    = ERR_RSP;
         made = 1'b1;
         if (lst) clear_decoder();
         else err_seen = 1'b1;
         return;
      end
      if (lst) begin
         made = 1'b1;
         if (phase != HS_BODY || esc_wait) begin
            r = ERR_RSP;
         end else if (st == STEP_COLUMN) begin
            r = want_rsp(RK_SIZE, pat_kind, hdr_num, strip_cnt, bm_col, bm_cells,
                         5 * (strip_cnt + 1), width_max);
         end else begin
            r = want_rsp(RK_SIZE, pat_kind, hdr_num, strip_cnt, col_cnt, 0,
                         5 * (strip_cnt + 1), width_max);
         end
         clear_decoder();
         return;
      end
      if (st == STEP_HEADER) begin
         r    = want_rsp(RK_HEADER, pat_kind, hdr_num, 0, 0, 0, 0, 0);
         made = 1'b1;
      end else if (st == STEP_COLUMN) begin
         r    = want_rsp(RK_COLUMN, pat_kind, hdr_num, strip_cnt, bm_col, bm_cells, 0, 0);
         made = 1'b1;
      end
   endfunction

   table_row_type dir_rows [25] = '{
      '{CH_X,     1'b0, 1'b0, NO_RSP},
      '{CH_P,     1'b0, 1'b0, NO_RSP},
      '{"1",      1'b0, 1'b0, NO_RSP},
      '{CH_UNDER, 1'b0, 1'b1, want_rsp(RK_HEADER, PK_OSC, 1, 0, 0, 0, 0, 0)},
      '{"0",      1'b0, 1'b1, want_rsp(RK_COLUMN, PK_OSC, 1, 0, 0, 0, 0, 0)},
      '{"v",      1'b0, 1'b1, want_rsp(RK_COLUMN, PK_OSC, 1, 0, 1, 31, 0, 0)},
      '{CH_W,     1'b0, 1'b0, NO_RSP},
      '{CH_X,     1'b0, 1'b0, NO_RSP},
      '{CH_Y,     1'b0, 1'b0, NO_RSP},
      '{"9",      1'b0, 1'b0, NO_RSP},
      '{CH_Z,     1'b0, 1'b0, NO_RSP},
      '{"3",      1'b1, 1'b1, want_rsp(RK_SIZE, PK_OSC, 1, 1, 0, 3, 10, 20)},
      '{8'h00,    1'b0, 1'b1, ERR_RSP},
      '{8'hFF,    1'b1, 1'b1, ERR_RSP},
      '{CH_X,     1'b0, 1'b0, NO_RSP},
      '{CH_Q,     1'b0, 1'b0, NO_RSP},
      '{"7",      1'b0, 1'b0, NO_RSP},
      '{CH_UNDER, 1'b1, 1'b1, want_rsp(RK_SIZE, PK_SHIP, 7, 0, 0, 0, 5, 0)},
      '{CH_X,     1'b0, 1'b0, NO_RSP},
      '{CH_S,     1'b1, 1'b1, ERR_RSP},
      '{CH_X,     1'b0, 1'b0, NO_RSP},
      '{CH_S,     1'b0, 1'b0, NO_RSP},
      '{CH_UNDER, 1'b1, 1'b1, ERR_RSP},
      '{CH_M,     1'b0, 1'b0, NO_RSP},
      '{"a",      1'b1, 1'b1, ERR_RSP}
   };

   // one random code: mostly well formed, some broken, some noise
   task automatic add_code(input bit drain_first);
      logic [7:0]    txt [$];
      code_char_type cc;
      int            form, n, pick, shape, pos;
      bit            nines;
      form = $urandom_range(0, 19);
      if (form < 2) begin
         n = $urandom_range(1, 8);
         repeat (n) txt.insert(txt.size(), 8'($urandom_range(0, 255)));
      end else begin
         pick = $urandom_range(0, 3);
         if (pick == 3) begin
            for (int i = 0; i < 10; i++) txt.insert(txt.size(), meth_word[i]);
         end else begin
            txt.insert(txt.size(), CH_X);
            txt.insert(txt.size(), pick == 0 ? CH_S : pick == 1 ? CH_P : CH_Q);
         end
         n     = $urandom_range(1, 6);
         nines = ($urandom_range(0, 7) == 0);
         repeat (n) txt.insert(txt.size(), nines ? 8'("9") : digit36($urandom_range(0, 9)));
         txt.insert(txt.size(), CH_UNDER);
         // shape 0: wide skips to overrun columns, 1: many strips
         shape = $urandom_range(0, 9);
         n     = (shape < 2) ? $urandom_range(8, 40) : $urandom_range(0, 14);
         repeat (n) begin
            pick = $urandom_range(0, 19);
            if (shape == 0) pick = (pick < 14) ? 15 : 0;
            else if (shape == 1) pick = (pick < 12) ? 18 : 0;
            if (pick <= 10) begin
               txt.insert(txt.size(), digit36($urandom_range(0, 31)));
            end else if (pick <= 12) begin
               txt.insert(txt.size(), CH_W);
            end else if (pick <= 14) begin
               txt.insert(txt.size(), CH_X);
            end else if (pick <= 17) begin
               txt.insert(txt.size(), CH_Y);
               txt.insert(txt.size(), digit36(shape == 0 ? $urandom_range(25, 35)
                                                         : $urandom_range(0, 35)));
            end else begin
               txt.insert(txt.size(), CH_Z);
            end
         end
         if (form < 5) begin
            pos = $urandom_range(0, txt.size() - 1);
            case ($urandom_range(0, 2))
               0: txt[pos] = 8'($urandom_range(0, 255));
               1: while (txt.size() > pos + 1) void'(txt.pop_back());
               default: txt.insert(txt.size(), CH_Y);
            endcase
         end
      end
      foreach (txt[i]) begin
         cc.ch    = txt[i];
         cc.last  = (i == txt.size() - 1);
         cc.typed = 1'b0;
         cc.drain = drain_first && (i == 0);
         cc.want  = NO_RSP;
         code_chars.insert(code_chars.size(), cc);
      end
   endtask

   task automatic send_char(input code_char_type cc);
      int gap;
      gap = 0;
      if ($urandom_range(0, 63) == 0) send_rate = $urandom_range(0, 2) * 6;
      if (acc_idx + CALM_TAIL < code_chars.size() && send_rate != 0 &&
          $urandom_range(1, send_rate) == 1)
         gap = $urandom_range(1, 19);
      if (gap > 0 || (cc.drain && rsp_due.size() != 0)) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
         while (cc.drain && rsp_due.size() != 0) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.ch    <= cc.ch;
      req_if.last  <= cc.last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // result sink with stall bursts
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(negedge clock);
         if (cycles % 200 == 0) rcv_rate = $urandom_range(0, 2) * 5;
         if (stall == 0 && acc_idx + CALM_TAIL < code_chars.size() && rcv_rate != 0 &&
             $urandom_range(1, rcv_rate) == 1)
            stall = $urandom_range(1, 19);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            stall--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      rsp_type got, exp;
      bit      made;
      string   bad;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            got.kind          = rsp_if.kind;
            got.pattern_kind  = rsp_if.pattern_kind;
            got.header_number = rsp_if.header_number;
            got.strip         = rsp_if.strip;
            got.column        = rsp_if.column;
            got.cells         = rsp_if.cells;
            got.grid_height   = rsp_if.grid_height;
            got.grid_width    = rsp_if.grid_width;
            rsp_count[got.kind]++;
            if (rsp_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected result item: %s", show_rsp(got));
            end else begin
               exp = rsp_due.pop_front();
               bad = "";
               if (got.kind !== exp.kind) bad = {bad, " kind"};
               if (got.pattern_kind !== exp.pattern_kind) bad = {bad, " pattern_kind"};
               if (got.header_number !== exp.header_number) bad = {bad, " header_number"};
               if (got.strip !== exp.strip) bad = {bad, " strip"};
               if (got.column !== exp.column) bad = {bad, " column"};
               if (got.cells !== exp.cells) bad = {bad, " cells"};
               if (got.grid_height !== exp.grid_height) bad = {bad, " grid_height"};
               if (got.grid_width !== exp.grid_width) bad = {bad, " grid_width"};
               if (bad != "") begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("wrong field(s)%s\n   expected %s\n   actual   %s", bad,
                              show_rsp(exp), show_rsp(got));
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            decode_char(req_if.ch, req_if.last, made, exp);
            if (code_chars[acc_idx].typed)
               rsp_due.insert(rsp_due.size(), code_chars[acc_idx].want);
            else if (made) rsp_due.insert(rsp_due.size(), exp);
            if (req_if.last) codes_done++;
            acc_idx++;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d result items still due", cycles,
                  rsp_due.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      code_char_type cc;
      reset        = 1'b1;
      req_if.valid = 1'b0;
      req_if.ch    = '0;
      req_if.last  = 1'b0;
      rsp_if.ready = 1'b0;
      clear_decoder();
      foreach (dir_rows[i]) begin
         cc.ch    = dir_rows[i].ch;
         cc.last  = dir_rows[i].last;
         cc.typed = dir_rows[i].typed;
         cc.drain = 1'b0;
         cc.want  = dir_rows[i].want;
         code_chars.insert(code_chars.size(), cc);
      end
      add_code(1'b1);
      while (code_chars.size() < CHAR_TARGET) add_code($urandom_range(0, 11) == 0);

      repeat (9) @(negedge clock);
      reset <= 1'b0;
      foreach (code_chars[i]) send_char(code_chars[i]);
      req_if.valid <= 1'b0;

      while (rsp_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("covered %0d codes in %0d characters, %0d mismatches", codes_done, acc_idx,
               fail_count);
      $display("result items: %0d header, %0d column, %0d size, %0d error", rsp_count[0],
               rsp_count[1], rsp_count[2], rsp_count[3]);
      if (fail_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
